/* rtl/ipv4rx_pkg.sv */
// Package for the IPv4 receive header checker.
// Holds the header layout, protocol numbers, verdict codes and the result record.
// No dependencies.
package ipv4rx_pkg;

    localparam int HEADER_BYTES = 20;

    localparam logic [15:0] HDR_LEN      = 16'(HEADER_BYTES);
    localparam logic [15:0] IDX_VERSION  = 16'd0;
    localparam logic [15:0] IDX_LEN_HI   = 16'd2;
    localparam logic [15:0] IDX_LEN_LO   = 16'd3;
    localparam logic [15:0] IDX_PROTO    = 16'd9;
    localparam logic [15:0] IDX_CHECK_HI = 16'd10;
    localparam logic [15:0] IDX_CHECK_LO = 16'd11;
    localparam logic [15:0] IDX_SRC_LO   = 16'd12;
    localparam logic [15:0] IDX_SRC_HI   = 16'd15;
    localparam logic [15:0] IDX_DST_LO   = 16'd16;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    localparam logic [3:0] IP_VERSION_4 = 4'd4;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic REG_LOCAL_ADDRESS = 1'b0;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT    = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_VERSION   = 3'd2,
        VERDICT_CHECKSUM  = 3'd3,
        VERDICT_LENGTH    = 3'd4,
        VERDICT_NOT_LOCAL = 3'd5
    } t_verdict;

    typedef enum logic [1:0] {
        CLASS_ICMP  = 2'd0,
        CLASS_TCP   = 2'd1,
        CLASS_UDP   = 2'd2,
        CLASS_OTHER = 2'd3
    } t_proto_class;

    typedef struct packed {
        t_verdict     verdict;
        t_proto_class protocol_class;
        logic [7:0]   protocol_number;
        logic [31:0]  source_address;
        logic [15:0]  payload_length;
    } t_result;

endpackage

/* rtl/ipv4rx_in_if.sv */
// Byte stream channel into the IPv4 receive header checker.
// Carries valid, ready and one packet byte with its last marker. No dependencies.
interface ipv4rx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

/* rtl/ipv4rx_out_if.sv */
// Result channel out of the IPv4 receive header checker.
// Carries valid, ready and one verdict record per packet. No dependencies.
interface ipv4rx_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [1:0]  protocol_class;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [15:0] payload_length;

    modport source (output valid, output verdict, output protocol_class,
                    output protocol_number, output source_address,
                    output payload_length, input ready);
    modport sink   (input valid, input verdict, input protocol_class,
                    input protocol_number, input source_address,
                    input payload_length, output ready);
endinterface

/* rtl/ipv4rx_hdr_eval.sv */
// Per-packet header state and verdict logic of the IPv4 receive header checker.
// Depends on ipv4rx_pkg.
module ipv4rx_hdr_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last,
    input  logic [31:0]         i_local_address,
    output ipv4rx_pkg::t_result o_result
);
    import ipv4rx_pkg::*;

    logic [15:0] r_count, n_count;
    logic [19:0] r_sum, n_sum;
    logic [15:0] r_check, n_check;
    logic [3:0]  r_version, n_version;
    logic [15:0] r_total_len, n_total_len;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;

    logic [16:0] fold_1;
    logic [15:0] fold_2;
    logic [15:0] expect_check;

    always_comb begin
        n_sum       = r_sum;
        n_check     = r_check;
        n_version   = r_version;
        n_total_len = r_total_len;
        n_proto     = r_proto;
        n_src       = r_src;
        n_dst       = r_dst;
        if (r_count < HDR_LEN) begin
            if (r_count != IDX_CHECK_HI && r_count != IDX_CHECK_LO) begin
                n_sum = r_sum + (r_count[0] ? {12'b0, i_data_byte}
                                            : {4'b0, i_data_byte, 8'b0});
            end
            if (r_count == IDX_VERSION) begin
                n_version = i_data_byte[7:4];
            end else if (r_count == IDX_LEN_HI || r_count == IDX_LEN_LO) begin
                n_total_len = {r_total_len[7:0], i_data_byte};
            end else if (r_count == IDX_PROTO) begin
                n_proto = i_data_byte;
            end else if (r_count == IDX_CHECK_HI || r_count == IDX_CHECK_LO) begin
                n_check = {r_check[7:0], i_data_byte};
            end else if (r_count >= IDX_SRC_LO && r_count <= IDX_SRC_HI) begin
                n_src = {r_src[23:0], i_data_byte};
            end else if (r_count >= IDX_DST_LO) begin
                n_dst = {r_dst[23:0], i_data_byte};
            end
        end
        n_count = (r_count != COUNT_MAX) ? r_count + 16'd1 : r_count;
    end

    // two folds bring a 20-bit sum of nine words into 16 bits
    always_comb begin
        fold_1       = {1'b0, n_sum[15:0]} + {13'b0, n_sum[19:16]};
        fold_2       = fold_1[15:0] + {15'b0, fold_1[16]};
        expect_check = ~fold_2;
    end

    always_comb begin
        o_result.protocol_number = n_proto;
        o_result.source_address  = n_src;
        o_result.payload_length  = 16'd0;
        if (n_count < HDR_LEN) begin
            o_result.verdict = VERDICT_SHORT;
        end else if (n_version != IP_VERSION_4) begin
            o_result.verdict = VERDICT_VERSION;
        end else if (expect_check != n_check) begin
            o_result.verdict = VERDICT_CHECKSUM;
        end else if (n_total_len > n_count || n_total_len < HDR_LEN) begin
            o_result.verdict = VERDICT_LENGTH;
        end else if (n_dst != i_local_address) begin
            o_result.verdict = VERDICT_NOT_LOCAL;
        end else begin
            o_result.verdict        = VERDICT_ACCEPT;
            o_result.payload_length = n_total_len - HDR_LEN;
        end
        case (n_proto)
            PROTO_ICMP: o_result.protocol_class = CLASS_ICMP;
            PROTO_TCP:  o_result.protocol_class = CLASS_TCP;
            PROTO_UDP:  o_result.protocol_class = CLASS_UDP;
            default:    o_result.protocol_class = CLASS_OTHER;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_check     <= '0;
            r_version   <= '0;
            r_total_len <= '0;
            r_proto     <= '0;
            r_src       <= '0;
            r_dst       <= '0;
        end else if (i_step) begin
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_check     <= n_check;
            r_version   <= n_version;
            r_total_len <= n_total_len;
            r_proto     <= n_proto;
            r_src       <= n_src;
            r_dst       <= n_dst;
        end
    end
endmodule

/* rtl/ipv4_rx_header_checker.sv */
// Top level of the IPv4 receive header checker.
// Depends on ipv4rx_pkg, ipv4rx_in_if, ipv4rx_out_if and ipv4rx_hdr_eval.
//
// Takes one packet byte per cycle while the input is not stalled, header first
// in network order, and gives one result per packet: the verdict, the protocol
// class and number, the source address and, on acceptance, the payload length.
// Each byte passes through the input register into the header evaluator, and the
// verdict for a last byte is loaded into the result register, which offers it to
// the sink. Bytes otherwise stream at one per cycle; the input stalls only
// while a last byte waits for a full result register that the sink has not taken.
// local_address sits at APB byte address 0 and should be written between packets.
module ipv4_rx_header_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipv4rx_in_if.sink    i_hdr,
    ipv4rx_out_if.source o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ipv4rx_pkg::*;

    logic [31:0] r_local_address;

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;
    logic        s1_go;
    logic        out_free;

    logic        r_out_valid;
    t_result     r_out;
    t_result     eval_result;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOCAL_ADDRESS) ? r_local_address : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_LOCAL_ADDRESS) begin
            r_local_address <= pwdata;
        end
    end

    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_go       = r_s1_valid && (!r_s1_last || out_free);
    assign i_hdr.ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_hdr.ready) begin
            r_s1_valid <= i_hdr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hdr.ready && i_hdr.valid) begin
            r_s1_byte <= i_hdr.data_byte;
            r_s1_last <= i_hdr.last;
        end
    end

    ipv4rx_hdr_eval u_eval (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (s1_go),
        .i_data_byte     (r_s1_byte),
        .i_last          (r_s1_last),
        .i_local_address (r_local_address),
        .o_result        (eval_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out <= eval_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.verdict         = r_out.verdict;
    assign o_res.protocol_class  = r_out.protocol_class;
    assign o_res.protocol_number = r_out.protocol_number;
    assign o_res.source_address  = r_out.source_address;
    assign o_res.payload_length  = r_out.payload_length;

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_go |=> r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_last))
        else $error("stalled input stage lost its byte");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.verdict != VERDICT_ACCEPT |-> r_out.payload_length == 16'd0)
        else $error("payload length given on a rejected packet");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |-> !(s1_go && r_s1_last))
        else $error("result overwritten before transfer");
endmodule
